### sv/zdad_pkg.sv
// Shared types, constants and delta tables for the delta audio decoder.
`timescale 1ns / 1ps

package zdad_pkg;

  localparam int MaxChunkBytesDefault = 65535;
  localparam int FifoDepth = 4;
  localparam int FifoPtrW = $clog2(FifoDepth);
  localparam logic [7:0] PredInit = 8'd128;
  localparam logic [15:0] UsedMax = 16'hFFFF;

  typedef enum logic [2:0] {
    KIND_PACK2,
    KIND_PACK4,
    KIND_DELTA,
    KIND_RAW,
    KIND_REPEAT
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic [5:0]  last_idx;
    logic        init;
    logic        done;
    logic [15:0] used;
  } entry_t;

  function automatic logic signed [4:0] tab2(input logic [1:0] code);
    logic signed [4:0] d;
    case (code)
      2'd0: d = -5'sd2;
      2'd1: d = -5'sd1;
      2'd2: d = 5'sd0;
      default: d = 5'sd1;
    endcase
    return d;
  endfunction

  function automatic logic signed [4:0] tab4(input logic [3:0] code);
    logic signed [4:0] d;
    case (code)
      4'd0: d = -5'sd9;
      4'd1: d = -5'sd8;
      4'd2: d = -5'sd6;
      4'd3: d = -5'sd5;
      4'd4: d = -5'sd4;
      4'd5: d = -5'sd3;
      4'd6: d = -5'sd2;
      4'd7: d = -5'sd1;
      4'd8: d = 5'sd0;
      4'd9: d = 5'sd1;
      4'd10: d = 5'sd2;
      4'd11: d = 5'sd3;
      4'd12: d = 5'sd4;
      4'd13: d = 5'sd5;
      4'd14: d = 5'sd6;
      default: d = 5'sd8;
    endcase
    return d;
  endfunction

  function automatic logic [7:0] sat_add(input logic [7:0] p, input logic signed [4:0] d);
    logic signed [9:0] v;
    logic [7:0] r;
    v = $signed({2'b00, p}) + $signed({{5{d[4]}}, d});
    if (v < 10'sd0) begin
      r = 8'd0;
    end else if (v > 10'sd255) begin
      r = 8'd255;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

### sv/zdad_front.sv
// Front end: parses opcodes, tracks chunk state and queues sample-producing bytes.
`timescale 1ns / 1ps

module zdad_front #(
  parameter int MAX_CHUNK_BYTES = zdad_pkg::MaxChunkBytesDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         byte_value_i,
  input  logic               chunk_start_i,
  input  logic [15:0]        chunk_samples_i,
  output logic               entry_valid_o,
  output zdad_pkg::entry_t   entry_o
);

  localparam int CntW = $clog2(MAX_CHUNK_BYTES + 1);

  typedef enum logic [1:0] {
    PH_OPCODE,
    PH_PACK2,
    PH_PACK4,
    PH_RAW
  } phase_e;

  phase_e            phase_q, phase_d, eff_phase;
  logic [6:0]        left_q, left_d, eff_left, left_dec, count;
  logic [15:0]       rem_q, rem_d, eff_rem;
  logic [CntW-1:0]   cnt_q, cnt_d, eff_cnt, cnt_inc;
  logic [CntW+15:0]  cnt_ext;
  logic              fin_q, fin_d, eff_fin;
  logic              fresh_q, fresh_d, eff_fresh;
  logic              emit, cmd_done;
  logic [6:0]        n;
  zdad_pkg::kind_e   kind;

  always_comb begin
    eff_phase = chunk_start_i ? PH_OPCODE : phase_q;
    eff_left  = chunk_start_i ? 7'd0 : left_q;
    eff_rem   = chunk_start_i ? chunk_samples_i : rem_q;
    eff_cnt   = chunk_start_i ? '0 : cnt_q;
    eff_fin   = chunk_start_i ? (chunk_samples_i == 16'd0) : fin_q;
    eff_fresh = chunk_start_i ? 1'b1 : fresh_q;

    cnt_inc = (eff_cnt < CntW'(MAX_CHUNK_BYTES)) ? eff_cnt + 1'b1 : eff_cnt;
    cnt_ext = {16'd0, cnt_inc};
    count   = {1'b0, byte_value_i[5:0]} + 7'd1;
    left_dec = (eff_left > 7'd0) ? eff_left - 7'd1 : 7'd0;

    phase_d  = eff_phase;
    left_d   = eff_left;
    emit     = 1'b0;
    cmd_done = 1'b0;
    n        = 7'd1;
    kind     = zdad_pkg::KIND_RAW;

    if (!eff_fin) begin
      if (eff_phase == PH_OPCODE) begin
        case (byte_value_i[7:6])
          2'd0: begin
            phase_d = PH_PACK2;
            left_d  = count;
          end
          2'd1: begin
            phase_d = PH_PACK4;
            left_d  = count;
          end
          2'd2: begin
            if (byte_value_i[5]) begin
              emit     = 1'b1;
              cmd_done = 1'b1;
              kind     = zdad_pkg::KIND_DELTA;
            end else begin
              phase_d = PH_RAW;
              left_d  = count;
            end
          end
          default: begin
            emit     = 1'b1;
            cmd_done = 1'b1;
            kind     = zdad_pkg::KIND_REPEAT;
            n        = count;
          end
        endcase
      end else begin
        emit   = 1'b1;
        left_d = left_dec;
        case (eff_phase)
          PH_PACK2: begin
            kind = zdad_pkg::KIND_PACK2;
            n    = 7'd4;
          end
          PH_PACK4: begin
            kind = zdad_pkg::KIND_PACK4;
            n    = 7'd2;
          end
          default: begin
            kind = zdad_pkg::KIND_RAW;
            n    = 7'd1;
          end
        endcase
        if (left_dec == 7'd0) begin
          phase_d  = PH_OPCODE;
          cmd_done = 1'b1;
        end
      end
    end

    rem_d   = eff_rem;
    if (emit) begin
      rem_d = (eff_rem > {9'd0, n}) ? eff_rem - {9'd0, n} : 16'd0;
    end
    fin_d   = eff_fin ? 1'b1 : (cmd_done && rem_d == 16'd0);
    cnt_d   = eff_fin ? eff_cnt : cnt_inc;
    fresh_d = emit ? 1'b0 : eff_fresh;

    entry_o.kind     = kind;
    entry_o.data     = byte_value_i;
    entry_o.last_idx = 6'(n - 7'd1);
    entry_o.init     = eff_fresh;
    entry_o.done     = fin_d;
    entry_o.used     = (cnt_ext > (CntW + 16)'(zdad_pkg::UsedMax)) ? zdad_pkg::UsedMax
                                                                   : cnt_ext[15:0];
  end

  assign entry_valid_o = accept_i && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_OPCODE;
      left_q  <= 7'd0;
      rem_q   <= 16'd0;
      cnt_q   <= '0;
      fin_q   <= 1'b1;
      fresh_q <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      left_q  <= left_d;
      rem_q   <= rem_d;
      cnt_q   <= cnt_d;
      fin_q   <= fin_d;
      fresh_q <= fresh_d;
    end
  end

endmodule

### sv/zdad_fifo.sv
// Short queue of decoded byte entries between the front and back ends.
`timescale 1ns / 1ps

module zdad_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  zdad_pkg::entry_t  wr_data_i,
  output logic              full_o,
  input  logic              rd_i,
  output zdad_pkg::entry_t  rd_data_o,
  output logic              empty_o
);

  localparam int PtrW = zdad_pkg::FifoPtrW;

  zdad_pkg::entry_t mem_q [zdad_pkg::FifoDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]    cnt_q;
  logic             do_wr, do_rd;

  assign full_o    = (cnt_q == (PtrW + 1)'(zdad_pkg::FifoDepth));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10: cnt_q <= cnt_q + 1'b1;
        2'b01: cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

### sv/zdad_back.sv
// Back end: expands queued entries into samples and holds the output register.
`timescale 1ns / 1ps

module zdad_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  zdad_pkg::entry_t  head_i,
  input  logic              head_empty_i,
  output logic              head_pop_o,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [7:0]        sample_o,
  output logic              last_of_run_o,
  output logic              chunk_done_o,
  output logic [15:0]       bytes_used_o
);

  logic [5:0]        idx_q, idx_d;
  logic [7:0]        pred_q, base, smp;
  logic              out_v_q, adv, last;
  logic [7:0]        sample_q;
  logic              last_q, done_q;
  logic [15:0]       used_q;
  logic [7:0]        shifted;
  logic signed [4:0] d5;

  assign empty_o = !out_v_q;
  assign adv     = !head_empty_i && (!out_v_q || pop_i);
  assign last    = (idx_q == head_i.last_idx);
  assign head_pop_o = adv && last;

  always_comb begin
    base    = (idx_q == 6'd0 && head_i.init) ? zdad_pkg::PredInit : pred_q;
    shifted = head_i.data >> {idx_q[1:0], 1'b0};
    d5      = $signed(head_i.data[4:0]);
    case (head_i.kind)
      zdad_pkg::KIND_PACK2: smp = zdad_pkg::sat_add(base, zdad_pkg::tab2(shifted[1:0]));
      zdad_pkg::KIND_PACK4: smp = zdad_pkg::sat_add(base, zdad_pkg::tab4(
                                idx_q[0] ? head_i.data[7:4] : head_i.data[3:0]));
      zdad_pkg::KIND_DELTA: smp = base + {{3{d5[4]}}, d5};
      zdad_pkg::KIND_RAW:   smp = head_i.data;
      default:              smp = base;
    endcase
    idx_d = last ? 6'd0 : idx_q + 6'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 6'd0;
      pred_q  <= zdad_pkg::PredInit;
      out_v_q <= 1'b0;
    end else begin
      if (adv) begin
        idx_q   <= idx_d;
        pred_q  <= smp;
        out_v_q <= 1'b1;
      end else if (pop_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sample_q <= smp;
      last_q   <= last;
      done_q   <= last && head_i.done;
      used_q   <= head_i.used;
    end
  end

  assign sample_o      = sample_q;
  assign last_of_run_o = last_q;
  assign chunk_done_o  = done_q;
  assign bytes_used_o  = used_q;

endmodule

### sv/zap_delta_audio_decoder_unit.sv
// Top level of the delta audio decoder: front end, entry queue and sample back end.
//
//   channel  | beat moves on          | payload
//   ---------+------------------------+--------------------------------------------
//   input    | push high, full low    | byte_value_i, chunk_start_i, chunk_samples_i
//   result   | pop high, empty low    | sample_o, last_of_run_o, chunk_done_o,
//            |                        | bytes_used_o
//
// The front end takes one byte per cycle while the four-entry queue has room.
// Each queued byte occupies the back end's sample sequencer until it has yielded
// all of its samples: 4 for a two-bit packed byte, 2 for a four-bit packed
// byte, 1 for a delta or raw byte and 1 to 64 for a repeat opcode.
// Reset clears all control state at once; a stalled result holds the back end,
// and the front end stalls only when the queue fills.
`timescale 1ns / 1ps

module zap_delta_audio_decoder_unit #(
  parameter int MAX_CHUNK_BYTES = zdad_pkg::MaxChunkBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  byte_value_i,
  input  logic        chunk_start_i,
  input  logic [15:0] chunk_samples_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  sample_o,
  output logic        last_of_run_o,
  output logic        chunk_done_o,
  output logic [15:0] bytes_used_o
);

  zdad_pkg::entry_t wr_entry, head;
  logic             wr_valid, head_empty, head_pop, accept;

  assign accept = push && !full;

  zdad_front #(
    .MAX_CHUNK_BYTES(MAX_CHUNK_BYTES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .byte_value_i   (byte_value_i),
    .chunk_start_i  (chunk_start_i),
    .chunk_samples_i(chunk_samples_i),
    .entry_valid_o  (wr_valid),
    .entry_o        (wr_entry)
  );

  zdad_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (wr_valid),
    .wr_data_i(wr_entry),
    .full_o   (full),
    .rd_i     (head_pop),
    .rd_data_o(head),
    .empty_o  (head_empty)
  );

  zdad_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_empty_i (head_empty),
    .head_pop_o   (head_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .sample_o     (sample_o),
    .last_of_run_o(last_of_run_o),
    .chunk_done_o (chunk_done_o),
    .bytes_used_o (bytes_used_o)
  );

endmodule

### test/zap_delta_audio_decoder_unit_test.sv
// Directed and randomized test of the delta audio decoder against a behavioral sample predictor.
`timescale 1ns / 1ps

module zap_delta_audio_decoder_unit_test;

  localparam int MaxChunkBytes = zdad_pkg::MaxChunkBytesDefault;
  localparam int ItemTarget = 470;

  localparam logic [1:0] MODE_PACK2 = 2'd0;
  localparam logic [1:0] MODE_PACK4 = 2'd1;
  localparam logic [1:0] MODE_LITERAL = 2'd2;
  localparam logic [1:0] MODE_REPEAT = 2'd3;

  typedef enum logic [1:0] {
    ST_OPCODE,
    ST_PACK2,
    ST_PACK4,
    ST_RAW
  } dec_state_e;

  typedef struct {
    logic [7:0]  sample;
    logic        last;
    logic        done;
    logic [15:0] used;
  } sample_beat_t;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [7:0]  byte_value_i;
  logic        chunk_start_i;
  logic [15:0] chunk_samples_i;
  logic        empty;
  logic        pop;
  logic [7:0]  sample_o;
  logic        last_of_run_o;
  logic        chunk_done_o;
  logic [15:0] bytes_used_o;

  sample_beat_t pending_samples[$];
  int           errors;
  int           items_sent;
  bit           calm;

  logic [7:0]   pred_level;
  dec_state_e   dec_state;
  int           cmd_bytes_left;
  int           samples_owed;
  int           chunk_bytes;
  logic         chunk_idle;

  zap_delta_audio_decoder_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .byte_value_i    (byte_value_i),
    .chunk_start_i   (chunk_start_i),
    .chunk_samples_i (chunk_samples_i),
    .empty           (empty),
    .pop             (pop),
    .sample_o        (sample_o),
    .last_of_run_o   (last_of_run_o),
    .chunk_done_o    (chunk_done_o),
    .bytes_used_o    (bytes_used_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int step2_delta(logic [1:0] code);
    int d;
    case (code)
      2'd0: d = -2;
      2'd1: d = -1;
      2'd2: d = 0;
      default: d = 1;
    endcase
    return d;
  endfunction

  function automatic int step4_delta(logic [3:0] code);
    int d;
    case (code)
      4'd0: d = -9;
      4'd1: d = -8;
      4'd2: d = -6;
      4'd3: d = -5;
      4'd4: d = -4;
      4'd5: d = -3;
      4'd6: d = -2;
      4'd7: d = -1;
      4'd8: d = 0;
      4'd9: d = 1;
      4'd10: d = 2;
      4'd11: d = 3;
      4'd12: d = 4;
      4'd13: d = 5;
      4'd14: d = 6;
      default: d = 8;
    endcase
    return d;
  endfunction

  function automatic logic [7:0] clamp_level(int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  function automatic sample_beat_t make_beat(logic [7:0] s);
    sample_beat_t bt;
    bt.sample = s;
    bt.last = 1'b0;
    bt.done = 1'b0;
    bt.used = (chunk_bytes > 65535) ? zdad_pkg::UsedMax : chunk_bytes[15:0];
    if (samples_owed > 0) samples_owed--;
    return bt;
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic start, logic [15:0] req);
    sample_beat_t run [64];
    int   n;
    int   count;
    int   i;
    logic cmd_end;
    n = 0;
    cmd_end = 1'b0;
    if (start) begin
      pred_level = zdad_pkg::PredInit;
      dec_state = ST_OPCODE;
      cmd_bytes_left = 0;
      samples_owed = int'(req);
      chunk_bytes = 0;
      chunk_idle = (req == 16'd0);
    end
    if (chunk_idle) return;
    if (chunk_bytes < MaxChunkBytes) chunk_bytes++;
    count = int'(b[5:0]) + 1;
    if (dec_state == ST_OPCODE) begin
      case (b[7:6])
        MODE_PACK2: begin
          dec_state = ST_PACK2;
          cmd_bytes_left = count;
        end
        MODE_PACK4: begin
          dec_state = ST_PACK4;
          cmd_bytes_left = count;
        end
        MODE_LITERAL: begin
          if (b[5]) begin
            pred_level = pred_level + {{3{b[4]}}, b[4:0]};
            run[n] = make_beat(pred_level);
            n++;
            cmd_end = 1'b1;
          end else begin
            dec_state = ST_RAW;
            cmd_bytes_left = count;
          end
        end
        default: begin
          for (i = 0; i < count; i++) begin
            run[n] = make_beat(pred_level);
            n++;
          end
          cmd_end = 1'b1;
        end
      endcase
    end else begin
      if (dec_state == ST_PACK2) begin
        for (i = 0; i < 4; i++) begin
          pred_level = clamp_level(int'(pred_level) + step2_delta(b[2*i +: 2]));
          run[n] = make_beat(pred_level);
          n++;
        end
      end else if (dec_state == ST_PACK4) begin
        for (i = 0; i < 2; i++) begin
          pred_level = clamp_level(int'(pred_level) + step4_delta(b[4*i +: 4]));
          run[n] = make_beat(pred_level);
          n++;
        end
      end else begin
        pred_level = b;
        run[n] = make_beat(pred_level);
        n++;
      end
      if (cmd_bytes_left > 0) cmd_bytes_left--;
      if (cmd_bytes_left == 0) begin
        dec_state = ST_OPCODE;
        cmd_end = 1'b1;
      end
    end
    if (cmd_end && samples_owed == 0) chunk_idle = 1'b1;
    if (n > 0) begin
      run[n-1].last = 1'b1;
      if (cmd_end && chunk_idle) run[n-1].done = 1'b1;
    end
    for (i = 0; i < n; i++) pending_samples.push_back(run[i]);
  endfunction

  task automatic send_byte(logic [7:0] b, logic start, logic [15:0] req);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      push = 1'b0;
    end
    @(negedge clk_i);
    byte_value_i = b;
    chunk_start_i = start;
    chunk_samples_i = req;
    push = 1'b1;
    decode_byte(b, start, req);
    items_sent++;
    do @(posedge clk_i); while (full);
  endtask

  task automatic drain();
    @(negedge clk_i);
    push = 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic test_idle_and_zero();
    send_byte(8'hAA, 1'b0, 16'h1234);
    send_byte(8'hFF, 1'b1, 16'd0);
    send_byte(8'h55, 1'b0, 16'hFFFF);
  endtask

  task automatic test_saturation();
    send_byte({MODE_LITERAL, 6'h00}, 1'b1, 16'd200);
    send_byte(8'h01, 1'b0, 16'd0);
    send_byte({MODE_PACK2, 6'h00}, 1'b0, 16'd0);
    send_byte(8'h00, 1'b0, 16'd0);
    send_byte({MODE_LITERAL, 6'h00}, 1'b0, 16'd0);
    send_byte(8'hFF, 1'b0, 16'd0);
    send_byte({MODE_PACK2, 6'h00}, 1'b0, 16'd0);
    send_byte(8'hFF, 1'b0, 16'd0);
    send_byte({MODE_PACK4, 6'h00}, 1'b0, 16'd0);
    send_byte(8'hFF, 1'b0, 16'd0);
    send_byte({MODE_LITERAL, 6'h00}, 1'b0, 16'd0);
    send_byte(8'h03, 1'b0, 16'd0);
    send_byte({MODE_PACK4, 6'h00}, 1'b0, 16'd0);
    send_byte(8'h00, 1'b0, 16'd0);
  endtask

  task automatic test_delta_and_repeat();
    send_byte({MODE_LITERAL, 6'h3F}, 1'b1, 16'hFFFF);
    send_byte({MODE_LITERAL, 6'h30}, 1'b0, 16'd0);
    send_byte({MODE_LITERAL, 6'h2F}, 1'b0, 16'd0);
    send_byte({MODE_LITERAL, 6'h20}, 1'b0, 16'd0);
    send_byte({MODE_REPEAT, 6'h3F}, 1'b0, 16'd0);
    send_byte({MODE_REPEAT, 6'h00}, 1'b0, 16'd0);
  endtask

  task automatic test_restart_and_overshoot();
    send_byte({MODE_PACK2, 6'h3F}, 1'b1, 16'd50);
    send_byte(8'hE4, 1'b0, 16'd0);
    send_byte({MODE_REPEAT, 6'h09}, 1'b1, 16'd3);
    send_byte(8'hC3, 1'b0, 16'd7);
  endtask

  task automatic test_random_chunks();
    int          chunk_no;
    int          r;
    int          nbytes;
    int          k;
    logic [15:0] req;
    logic [7:0]  op;
    logic        first;
    logic        aborted;
    chunk_no = 0;
    while (items_sent < ItemTarget) begin
      calm = (chunk_no % 6 == 5);
      if (chunk_idle && $urandom_range(0, 9) == 0) begin
        send_byte(8'($urandom_range(0, 255)), 1'b0, 16'($urandom_range(0, 65535)));
      end
      r = $urandom_range(0, 99);
      if (r < 60) req = 16'($urandom_range(1, 40));
      else if (r < 75) req = 16'($urandom_range(41, 300));
      else if (r < 90) req = 16'($urandom_range(0, 65535));
      else if (r < 95) req = 16'd0;
      else req = 16'hFFFF;
      first = 1'b1;
      aborted = 1'b0;
      do begin
        op[7:6] = 2'($urandom_range(0, 3));
        op[5:0] = ($urandom_range(0, 99) < 75) ? 6'($urandom_range(0, 5))
                                                : 6'($urandom_range(0, 63));
        send_byte(op, first, first ? req : 16'($urandom_range(0, 65535)));
        first = 1'b0;
        if (op[7:6] == MODE_PACK2 || op[7:6] == MODE_PACK4 ||
            (op[7:6] == MODE_LITERAL && !op[5])) begin
          nbytes = int'(op[5:0]) + 1;
        end else begin
          nbytes = 0;
        end
        for (k = 0; k < nbytes && !aborted && !chunk_idle && items_sent < ItemTarget;
             k++) begin
          if ($urandom_range(0, 199) == 0) aborted = 1'b1;
          else send_byte(8'($urandom_range(0, 255)), 1'b0, 16'($urandom_range(0, 65535)));
        end
      end while (!chunk_idle && !aborted && items_sent < ItemTarget);
      chunk_no++;
    end
    calm = 1'b0;
  endtask

  // The consumer side stalls at random; each accepted beat is checked in order.
  initial begin
    int hold;
    hold = 0;
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        pop = 1'b0;
        hold--;
      end else begin
        pop = 1'b1;
        hold = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    sample_beat_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_samples.size() == 0) begin
        $error("unexpected sample beat: sample %0d", sample_o);
        errors++;
      end else begin
        want = pending_samples.pop_front();
        if (sample_o !== want.sample) begin
          $error("sample: expected %0d, got %0d", want.sample, sample_o);
          errors++;
        end
        if (last_of_run_o !== want.last) begin
          $error("last_of_run: expected %0d, got %0d", want.last, last_of_run_o);
          errors++;
        end
        if (chunk_done_o !== want.done) begin
          $error("chunk_done: expected %0d, got %0d", want.done, chunk_done_o);
          errors++;
        end
        if (bytes_used_o !== want.used) begin
          $error("bytes_used: expected %0d, got %0d", want.used, bytes_used_o);
          errors++;
        end
      end
    end
  end

  initial begin
    errors = 0;
    items_sent = 0;
    calm = 1'b0;
    push = 1'b0;
    byte_value_i = 8'd0;
    chunk_start_i = 1'b0;
    chunk_samples_i = 16'd0;
    pred_level = zdad_pkg::PredInit;
    dec_state = ST_OPCODE;
    cmd_bytes_left = 0;
    samples_owed = 0;
    chunk_bytes = 0;
    chunk_idle = 1'b1;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_idle_and_zero();
    drain();
    test_saturation();
    drain();
    test_delta_and_repeat();
    drain();
    test_restart_and_overshoot();
    drain();
    test_random_chunks();
    drain();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #(100_000_000);
    $display("tb: failure");
    $finish;
  end

endmodule
